### sv/pgd_pkg.sv
package pgd_pkg;

    // Samples gathered per median window.
    localparam int WINDOW = 5;
    // Middle position of a sorted window.
    localparam int MID = WINDOW / 2;
    // Width of the window position counter.
    localparam int IDX_W = $clog2(WINDOW);
    // Width of the index into the stored samples (the last sample of a
    // window is never stored, it is used straight from the input).
    localparam int WIN_IDX_W = $clog2(WINDOW - 1);
    // Width of a rank count inside the median selector.
    localparam int RANK_W = $clog2(WINDOW);

    localparam int CFG_DATA_W = 16;

    typedef logic [7:0]         cm_t;
    typedef logic signed [31:0] count_t;
    typedef logic [31:0]        travel_t;
    typedef logic [15:0]        req_travel_t;

    // Configuration register indexes.
    typedef enum logic {
        CFG_CLEARANCE  = 1'b0,
        CFG_REQ_TRAVEL = 1'b1
    } cfg_reg_t;

    // Input item kinds.
    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_CLEAR  = 1'b1
    } item_kind_t;

    localparam cm_t         CLEARANCE_RST  = 8'd40;
    localparam req_travel_t REQ_TRAVEL_RST = 16'd156;

endpackage

### sv/pgd_in_if.sv
interface pgd_in_if import pgd_pkg::*;;
    logic   valid;
    logic   ready;
    logic   kind;
    cm_t    sonar_cm;
    count_t wheel_count;

    modport source (output valid, kind, sonar_cm, wheel_count, input ready);
    modport sink (input valid, kind, sonar_cm, wheel_count, output ready);
endinterface

### sv/pgd_out_if.sv
interface pgd_out_if import pgd_pkg::*;;
    logic    valid;
    logic    ready;
    logic    median_valid;
    cm_t     median_cm;
    travel_t gap_travel;
    logic    space_found;

    modport source (output valid, median_valid, median_cm, gap_travel, space_found,
                    input ready);
    modport sink (input valid, median_valid, median_cm, gap_travel, space_found,
                  output ready);
    modport monitor (input valid, ready, median_valid, median_cm, gap_travel,
                     space_found);
endinterface

### sv/pgd_median.sv
module pgd_median import pgd_pkg::*;
(
    input  cm_t samples [WINDOW],
    output cm_t median
);

    logic [RANK_W-1:0] rank [WINDOW];
    logic [WINDOW-1:0] is_mid;

    // Rank every sample against all others; ties are broken by position so
    // that exactly one sample lands on the middle rank.
    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW; j++)
            begin
                if (j != i)
                begin
                    if ((samples[j] < samples[i]) ||
                        ((samples[j] == samples[i]) && (j < i)))
                    begin
                        rank[i] = rank[i] + RANK_W'(1);
                    end
                end
            end
            is_mid[i] = (rank[i] == RANK_W'(MID));
        end
    end

    // Pick the sample that holds the middle rank.
    always_comb
    begin
        median = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            median = median | (samples[i] & {8{is_mid[i]}});
        end
    end

endmodule

### sv/parking_gap_detector_median5.sv
// The result of an accepted transfer passes through the input register and then the result register to the output.
// Throughput: one item per cycle while results are taken, set by a single pass through the median
// selector and the travel subtract and compare between input and result registers.
// While a finished result waits to be taken, the input accepts a new item only if the input register is empty.
// Reset (rst_n low, asynchronous) empties both registers, restores the
// configuration defaults and returns the search to its starting condition.
module parking_gap_detector_median5 import pgd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    pgd_in_if.sink                sample_ch,
    pgd_out_if.source             result_ch,
    input  logic                  cfg_we,
    input  cfg_reg_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers.
    cm_t         clearance_reg;
    req_travel_t req_travel_reg;

    // Input register.
    logic    in_valid_reg;
    logic    in_kind_reg;
    cm_t     in_sonar_reg;
    travel_t in_count_reg;

    // Search state.
    cm_t              win_reg [WINDOW-1];
    logic [IDX_W-1:0] sample_idx_reg;
    logic [IDX_W-1:0] sample_idx_next;
    travel_t          gap_start_reg;
    travel_t          gap_start_next;
    logic             first_pending_reg;
    logic             first_pending_next;
    logic             found_reg;
    logic             found_next;
    logic             win_we;

    // Result register.
    logic    res_valid_reg;
    logic    res_mvalid_reg;
    logic    res_mvalid_next;
    cm_t     res_median_reg;
    cm_t     res_median_next;
    travel_t res_travel_reg;
    travel_t res_travel_next;

    logic    advance;
    cm_t     med_samples [WINDOW];
    cm_t     median;
    travel_t gap_start_eff;
    travel_t diff;
    travel_t magnitude;

    // The item moves on when the result register is empty or being emptied.
    assign advance         = in_valid_reg && (!res_valid_reg || result_ch.ready);
    assign sample_ch.ready = !in_valid_reg || advance;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearance_reg  <= CLEARANCE_RST;
            req_travel_reg <= REQ_TRAVEL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CLEARANCE:  clearance_reg  <= cfg_data[7:0];
                CFG_REQ_TRAVEL: req_travel_reg <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample_ch.ready)
        begin
            in_valid_reg <= sample_ch.valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (sample_ch.valid && sample_ch.ready)
        begin
            in_kind_reg  <= sample_ch.kind;
            in_sonar_reg <= sample_ch.sonar_cm;
            in_count_reg <= travel_t'(sample_ch.wheel_count);
        end
    end

    // The window being completed is the stored samples plus the current one.
    always_comb
    begin
        for (int k = 0; k < WINDOW - 1; k++)
        begin
            med_samples[k] = win_reg[k];
        end
        med_samples[WINDOW-1] = in_sonar_reg;
    end

    pgd_median u_median (
        .samples (med_samples),
        .median  (median)
    );

    // The first sample after reset or clear opens the free stretch.
    assign gap_start_eff = first_pending_reg ? in_count_reg : gap_start_reg;
    assign diff          = gap_start_eff - in_count_reg;
    assign magnitude     = diff[31] ? (32'd0 - diff) : diff;

    // Next search state and result for the item in the input register.
    always_comb
    begin
        sample_idx_next    = sample_idx_reg;
        gap_start_next     = gap_start_reg;
        first_pending_next = first_pending_reg;
        found_next         = found_reg;
        win_we             = 1'b0;
        res_mvalid_next    = 1'b0;
        res_median_next    = '0;
        res_travel_next    = '0;

        priority if (in_kind_reg == KIND_CLEAR)
        begin
            sample_idx_next    = '0;
            gap_start_next     = '0;
            first_pending_next = 1'b1;
            found_next         = 1'b0;
        end
        else if (!found_reg)
        begin
            first_pending_next = 1'b0;
            gap_start_next     = gap_start_eff;
            if (sample_idx_reg == IDX_W'(WINDOW - 1))
            begin
                sample_idx_next = '0;
                res_mvalid_next = 1'b1;
                res_median_next = median;
                if (median >= clearance_reg)
                begin
                    res_travel_next = magnitude;
                    if (magnitude >= {16'd0, req_travel_reg})
                    begin
                        found_next = 1'b1;
                    end
                end
                else
                begin
                    gap_start_next = in_count_reg;
                end
            end
            else
            begin
                win_we          = 1'b1;
                sample_idx_next = sample_idx_reg + IDX_W'(1);
            end
        end
        else
        begin
            // A found space holds everything until a clear item arrives.
        end
    end

    // Search state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_idx_reg    <= '0;
            gap_start_reg     <= '0;
            first_pending_reg <= 1'b1;
            found_reg         <= 1'b0;
        end
        else if (advance)
        begin
            sample_idx_reg    <= sample_idx_next;
            gap_start_reg     <= gap_start_next;
            first_pending_reg <= first_pending_next;
            found_reg         <= found_next;
        end
    end

    // Stored window samples.
    always_ff @(posedge clk)
    begin
        if (advance && win_we)
        begin
            win_reg[sample_idx_reg[WIN_IDX_W-1:0]] <= in_sonar_reg;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_mvalid_reg <= res_mvalid_next;
            res_median_reg <= res_median_next;
            res_travel_reg <= res_travel_next;
        end
    end

    assign result_ch.valid        = res_valid_reg;
    assign result_ch.median_valid = res_mvalid_reg;
    assign result_ch.median_cm    = res_median_reg;
    assign result_ch.gap_travel   = res_travel_reg;
    // The sticky flag after an item is the search state it left behind.
    assign result_ch.space_found  = found_reg;

endmodule

### sv/pgd_checker.sv
module pgd_checker import pgd_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    res_valid,
    input logic    res_ready,
    input logic    median_valid,
    input cm_t     median_cm,
    input travel_t gap_travel,
    input logic    space_found
);

    // A stalled result keeps its place.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            $stable(median_cm) && $stable(gap_travel) &&
            $stable(median_valid) && $stable(space_found))
        else $error("result changed while stalled");

    // Without a completed window there is no median and no travel.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !median_valid |->
            (median_cm == 8'd0) && (gap_travel == 32'd0))
        else $error("median or travel reported without a completed window");

    // Reset leaves no result behind.
    assert property (@(posedge clk) !rst_n |=> !res_valid)
        else $error("result present right after reset");

endmodule

bind parking_gap_detector_median5 pgd_checker u_pgd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result_ch.valid),
    .res_ready    (result_ch.ready),
    .median_valid (result_ch.median_valid),
    .median_cm    (result_ch.median_cm),
    .gap_travel   (result_ch.gap_travel),
    .space_found  (result_ch.space_found)
);
